>>> src/sbpp_pkg.sv
// ----------------------------------------------------------------------------
// sbpp_pkg: shared types and constants of the section beat peak picker
// register indexes, register widths and reset values, result beat layout
// ----------------------------------------------------------------------------
package sbpp_pkg;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 10;
  localparam int LENGTH_W    = 8;
  localparam int FACTOR_W    = 10;
  localparam int OFFSET_W    = 7;
  localparam int THRESH_SHIFT = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_SECTION_LENGTH = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STD_FACTOR     = 4'd1;

  localparam logic [LENGTH_W-1:0] LENGTH_RESET = 8'd128;
  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 10'd256;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic                valid;
    logic                done;
  } beat_t;

endpackage

>>> src/section_beat_peak_picker.sv
// ----------------------------------------------------------------------------
// section_beat_peak_picker: beat detection over sections of rhythm samples
// loads a section into memory while keeping its sum and sum of squares,
// works out the variance threshold, then scans for strict local maxima
// above mean + k * stddev
// ----------------------------------------------------------------------------
//
// channel   dir  beat content
// s_*       in   s_tdata: sample (signed, SAMPLE_BITS bits, padded to bytes)
// m_*       out  m_tdata: beat_offset; m_tuser: beat_valid; m_tlast: section_done
// cfg_*     in   cfg_index 0 section_length, 1 std_factor_q8; cfg_data value
//
// a section takes n = len + 2 input beats at one per cycle, where len is
// section_length with zero read as one and lengths past SECTION_MAX clamped,
// then three products in the shared shift-add multiplier, then a memory scan
// and a closing beat; s_tready is low after a section's last sample is taken
// until its scan finishes; a stalled m_tready freezes the scan pipeline, and
// the result register lets the next section load while the final beat waits
// rst is synchronous: registers return to 128 and 256, sums and counts clear
// ----------------------------------------------------------------------------
module section_beat_peak_picker #(
  parameter int SECTION_MAX = 128,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // sample stream
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_tdata,   // [SAMPLE_BITS-1:0] sample
  // beat stream
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [7:0]                             m_tdata,   // [6:0] beat_offset
  output logic                                   m_tuser,   // [0] beat_valid
  output logic                                   m_tlast,   // section_done
  // register writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [sbpp_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [sbpp_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int STORE_DEPTH = SECTION_MAX + 2;
  localparam int AW  = $clog2(STORE_DEPTH);
  localparam int CW  = $clog2(STORE_DEPTH + 1);
  localparam int SW  = SAMPLE_BITS + CW;                 // signed sum
  localparam int MW  = SW - 1;                           // |sum|
  localparam int QW  = 2 * SAMPLE_BITS - 2 + CW;         // sum of squares
  localparam int VW  = 2 * SAMPLE_BITS - 2 + 2 * CW;     // n*Q - S*S
  localparam int KKW = 2 * sbpp_pkg::FACTOR_W;           // k_q8 squared
  localparam int RW  = VW + KKW;                         // threshold
  localparam int MBW = (MW > KKW) ? MW : KKW;
  localparam int LW  = sbpp_pkg::LENGTH_W;
  localparam int FW  = sbpp_pkg::FACTOR_W;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PREP,
    ST_MUL_NQ,
    ST_MUL_SS,
    ST_MUL_KV,
    ST_SCAN
  } state_t;

  state_t                        state;
  logic [LW-1:0]                 section_length;
  logic [FW-1:0]                 std_factor_q8;
  logic [AW-1:0]                 load_cnt;
  logic signed [SW-1:0]          run_sum;
  logic [QW-1:0]                 run_sq;
  logic [VW-1:0]                 var_q;
  logic [RW-1:0]                 thresh;

  logic [CW-1:0]                 len_eff;
  logic [CW-1:0]                 n_eff;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic signed [2*SAMPLE_BITS-1:0] sq_term;
  logic                          s_accept;
  logic                          load_last;
  logic signed [SW-1:0]          sum_neg;
  logic [MW-1:0]                 sum_abs;
  logic [KKW-1:0]                kk;
  logic [VW-1:0]                 var_next;
  logic                          adv;

  // multiplier control
  logic                          mul_start;
  logic [VW-1:0]                 mul_a;
  logic [MBW-1:0]                mul_b;
  logic [RW-1:0]                 mul_p;
  logic                          mul_done;

  // scan side
  logic                          scan_start;
  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;
  logic [SAMPLE_BITS-1:0]        rd_data;
  logic                          scan_emit;
  sbpp_pkg::beat_t               scan_beat;
  logic                          scan_done;

  // length zero acts as one, lengths past the store clamp to SECTION_MAX
  always_comb begin
    if (section_length == '0) begin
      len_eff = CW'(1);
    end else if (int'(section_length) > SECTION_MAX) begin
      len_eff = CW'(SECTION_MAX);
    end else begin
      len_eff = CW'(section_length);
    end
  end

  assign n_eff     = len_eff + CW'(2);
  assign sample    = s_tdata[SAMPLE_BITS-1:0];
  assign sq_term   = sample * sample;
  assign s_tready  = (state == ST_LOAD);
  assign s_accept  = s_tvalid && s_tready;
  assign load_last = CW'(load_cnt) == n_eff - CW'(1);
  assign cfg_ready = 1'b1;

  assign sum_neg   = -run_sum;
  assign sum_abs   = run_sum[SW-1] ? MW'(sum_neg) : MW'(run_sum);
  assign kk        = KKW'(std_factor_q8) * KKW'(std_factor_q8);
  assign var_next  = var_q - VW'(mul_p);

  // result register frees when empty or when taken this cycle
  assign adv        = !m_tvalid || m_tready;
  assign scan_start = (state == ST_MUL_KV) && mul_done;

  // threshold sequence: n*Q, then minus S*S, then times k^2
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state)
      ST_PREP: begin
        mul_start = 1'b1;
        mul_a     = VW'(run_sq);
        mul_b     = MBW'(n_eff);
      end
      ST_MUL_NQ: begin
        mul_start = mul_done;
        mul_a     = VW'(sum_abs);
        mul_b     = MBW'(sum_abs);
      end
      ST_MUL_SS: begin
        mul_start = mul_done;
        mul_a     = var_next;
        mul_b     = MBW'(kk);
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_LOAD;
      section_length <= sbpp_pkg::LENGTH_RESET;
      std_factor_q8  <= sbpp_pkg::FACTOR_RESET;
      load_cnt       <= '0;
      run_sum        <= '0;
      run_sq         <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      // result register
      if (scan_emit) begin
        m_tvalid <= 1'b1;
        m_tdata  <= 8'(scan_beat.offset);
        m_tuser  <= scan_beat.valid;
        m_tlast  <= scan_beat.done;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_LOAD: begin
          if (s_accept) begin
            run_sum <= run_sum + SW'(sample);
            run_sq  <= run_sq + QW'(sq_term[2*SAMPLE_BITS-2:0]);
            if (load_last) begin
              load_cnt <= '0;
              state    <= ST_PREP;
            end else begin
              load_cnt <= load_cnt + AW'(1);
            end
          end
        end
        ST_PREP: begin
          state <= ST_MUL_NQ;
        end
        ST_MUL_NQ: begin
          if (mul_done) begin
            var_q <= VW'(mul_p);
            state <= ST_MUL_SS;
          end
        end
        ST_MUL_SS: begin
          if (mul_done) begin
            var_q <= var_next;
            state <= ST_MUL_KV;
          end
        end
        ST_MUL_KV: begin
          if (mul_done) begin
            thresh <= mul_p;
            state  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            run_sum <= '0;
            run_sq  <= '0;
            state   <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase

      // a new length restarts the section being loaded
      if (cfg_valid && cfg_index == sbpp_pkg::REG_SECTION_LENGTH) begin
        section_length <= cfg_data[LW-1:0];
        load_cnt       <= '0;
        run_sum        <= '0;
        run_sq         <= '0;
      end
      if (cfg_valid && cfg_index == sbpp_pkg::REG_STD_FACTOR) begin
        std_factor_q8 <= cfg_data[FW-1:0];
      end
    end
  end

  sbpp_store #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW),
    .DW    (SAMPLE_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (s_accept),
    .wr_addr (load_cnt),
    .wr_data (sample),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sbpp_smul #(
    .A_W (VW),
    .B_W (MBW),
    .P_W (RW)
  ) u_smul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .p     (mul_p),
    .done  (mul_done)
  );

  sbpp_scan #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .AW          (AW),
    .CW          (CW),
    .SW          (SW),
    .RW          (RW)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .start   (scan_start),
    .adv     (adv),
    .n       (n_eff),
    .run_sum (run_sum),
    .thresh  (thresh),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .emit    (scan_emit),
    .beat    (scan_beat),
    .done    (scan_done)
  );

endmodule

>>> src/sbpp_store.sv
// ----------------------------------------------------------------------------
// sbpp_store: section sample memory
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module sbpp_store #(
  parameter int DEPTH = 130,
  parameter int AW    = 8,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  // writes happen while loading, reads while scanning: never the same cycle
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/sbpp_smul.sv
// ----------------------------------------------------------------------------
// sbpp_smul: shared shift-add multiplier
// one multiplier bit per cycle, stops once the remaining bits are zero
// ----------------------------------------------------------------------------
module sbpp_smul #(
  parameter int A_W = 48,
  parameter int B_W = 24,
  parameter int P_W = 68
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [A_W-1:0] a,
  input  logic [B_W-1:0] b,
  output logic [P_W-1:0] p,
  output logic           done
);

  logic           busy;
  logic [P_W-1:0] ma;
  logic [B_W-1:0] mb;
  logic [P_W-1:0] acc;

  assign p = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        ma   <= P_W'(a);
        mb   <= b;
        acc  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (mb == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          if (mb[0]) begin
            acc <= acc + ma;
          end
          ma <= ma << 1;
          mb <= mb >> 1;
        end
      end
    end
  end

endmodule

>>> src/sbpp_scan.sv
// ----------------------------------------------------------------------------
// sbpp_scan: peak scan over the stored section
// streams the memory through a three-sample window, tests each inner sample
// against the threshold in a short pipeline and holds back the latest beat
// ----------------------------------------------------------------------------
module sbpp_scan #(
  parameter int SAMPLE_BITS = 16,
  parameter int AW = 8,
  parameter int CW = 8,
  parameter int SW = 24,
  parameter int RW = 68
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          adv,
  input  logic [CW-1:0]                 n,
  input  logic signed [SW-1:0]          run_sum,
  input  logic [RW-1:0]                 thresh,
  output logic                          rd_en,
  output logic [AW-1:0]                 rd_addr,
  input  logic signed [SAMPLE_BITS-1:0] rd_data,
  output logic                          emit,
  output sbpp_pkg::beat_t               beat,
  output logic                          done
);

  localparam int OW   = sbpp_pkg::OFFSET_W;
  localparam int NCW  = SAMPLE_BITS + CW + 1;
  localparam int DMW  = SAMPLE_BITS + CW;
  localparam int D2W  = 2 * DMW;
  localparam int L2W  = (D2W > 64) ? 64 : D2W;
  localparam int LHW  = L2W + sbpp_pkg::THRESH_SHIFT;
  localparam int CMPW = (LHW > RW) ? LHW : RW;

  logic                          active;
  logic [AW-1:0]                 rd_cnt;
  // window stage
  logic                          v1;
  logic [AW-1:0]                 idx1;
  logic signed [SAMPLE_BITS-1:0] w0;
  logic signed [SAMPLE_BITS-1:0] w1;
  // n*x stage
  logic                          v2;
  logic                          peak2;
  logic [AW-1:0]                 off2;
  logic                          last2;
  logic signed [NCW-1:0]         nc2;
  // deviation stage
  logic                          v3;
  logic                          cand3;
  logic [AW-1:0]                 off3;
  logic                          last3;
  logic [DMW-1:0]                ad3;
  // square stage
  logic                          v4;
  logic                          cand4;
  logic [AW-1:0]                 off4;
  logic                          last4;
  logic [D2W-1:0]                d2_4;
  // held-back beat
  logic                          pend_valid;
  logic [AW-1:0]                 pend;
  logic                          flush;

  logic signed [NCW-1:0]         dev;
  logic                          dev_pos;
  logic [CMPW-1:0]               lhs;
  logic                          hit;

  assign rd_en   = active && adv;
  assign rd_addr = rd_cnt;

  assign dev     = nc2 - NCW'(run_sum);
  assign dev_pos = !dev[NCW-1] && (dev != '0);
  // square kept to 64 bits before the 2^16 scaling
  assign lhs     = CMPW'({d2_4[L2W-1:0], {sbpp_pkg::THRESH_SHIFT{1'b0}}});
  assign hit     = cand4 && (lhs > CMPW'(thresh));
  assign done    = adv && flush;

  always_comb begin
    emit = 1'b0;
    beat = '0;
    if (adv) begin
      if (flush) begin
        emit        = 1'b1;
        beat.offset = pend_valid ? OW'(pend) : '0;
        beat.valid  = pend_valid;
        beat.done   = 1'b1;
      end else if (v4 && hit && pend_valid) begin
        emit        = 1'b1;
        beat.offset = OW'(pend);
        beat.valid  = 1'b1;
        beat.done   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
      v4         <= 1'b0;
      pend_valid <= 1'b0;
      flush      <= 1'b0;
    end else if (start) begin
      active     <= 1'b1;
      rd_cnt     <= '0;
      pend_valid <= 1'b0;
      flush      <= 1'b0;
    end else if (adv) begin
      if (active) begin
        rd_cnt <= rd_cnt + AW'(1);
        if (CW'(rd_cnt) == n - CW'(1)) begin
          active <= 1'b0;
        end
      end
      v1   <= active;
      idx1 <= rd_cnt;
      if (v1) begin
        w0 <= w1;
        w1 <= rd_data;
      end
      // center is the sample before the one just read
      v2    <= v1 && (idx1 >= AW'(2));
      peak2 <= (w0 < w1) && (rd_data < w1);
      off2  <= idx1 - AW'(2);
      last2 <= CW'(idx1) == n - CW'(1);
      nc2   <= NCW'($signed({1'b0, n})) * NCW'(w1);

      v3    <= v2;
      cand3 <= peak2 && dev_pos;
      ad3   <= DMW'(dev);
      off3  <= off2;
      last3 <= last2;

      v4    <= v3;
      cand4 <= cand3;
      d2_4  <= D2W'(ad3) * D2W'(ad3);
      off4  <= off3;
      last4 <= last3;

      if (v4) begin
        if (hit) begin
          pend       <= off4;
          pend_valid <= 1'b1;
        end
        if (last4) begin
          flush <= 1'b1;
        end
      end
      if (flush) begin
        flush      <= 1'b0;
        pend_valid <= 1'b0;
      end
    end
  end

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: regression of the section beat peak picker
// streams sections of rhythm samples and register writes into the block,
// predicts each beat from its own copy of the section state and checks
// every result beat field by field under random gaps and backpressure
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sbpp_pkg::*;

  localparam int SECTION_MAX   = 128;
  localparam int SAMPLE_BITS   = 16;
  localparam int STORE_DEPTH   = SECTION_MAX + 2;
  localparam int RANDOM_ITEMS  = 40;
  localparam int STEADY_ITEMS  = 50;
  localparam int SETTLE_CYCLES = 300;     // covers load tail, multiplier and scan
  localparam int DRAIN_LIMIT   = 50000;
  localparam int HOLD_CYCLES   = 700;
  localparam int RUN_LIMIT_NS  = 1000000;

  // indexes past the register list, writes there must be ignored
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_FIRST = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LAST  = 4'd15;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 16'sh8000;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 16'sh7FFF;

  typedef enum int {
    SHAPE_FULL_RANGE,
    SHAPE_SPIKES,
    SHAPE_ALTERNATE,
    SHAPE_FLAT,
    SHAPE_EDGE_PEAKS
  } shape_e;

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    s_tvalid  = 1'b0;
  logic                    s_tready;
  logic [SAMPLE_BITS-1:0]  s_tdata   = '0;   // [15:0] sample
  logic                    m_tvalid;
  logic                    m_tready  = 1'b0;
  logic [7:0]              m_tdata;          // [6:0] beat_offset
  logic                    m_tuser;          // [0] beat_valid
  logic                    m_tlast;          // section_done
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_INDEX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data  = '0;

  // predictor state, a mirror of the block's registers and section memory
  logic [LENGTH_W-1:0]            mirror_length;
  logic [FACTOR_W-1:0]            mirror_factor;
  logic signed [SAMPLE_BITS-1:0]  section_samples [STORE_DEPTH];
  longint                         level_sum;
  longint                         energy_sum;
  int                             loaded_count;
  beat_t                          expected_beats [$];
  beat_t                          head_beat;

  // stimulus side bookkeeping
  logic [LENGTH_W-1:0] programmed_length = LENGTH_RESET;
  int                  error_count  = 0;
  int                  sent_items   = 0;
  bit                  idle_on      = 1'b1;
  int                  hold_request = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  section_beat_peak_picker #(
    .SECTION_MAX (SECTION_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // beat prediction
  // ---------------------------------------------------------------------------

  // zero length acts as one window, anything past the memory acts as full size
  function automatic int active_length(input logic [LENGTH_W-1:0] value);
    if (value == 0) return 1;
    if (value > SECTION_MAX) return SECTION_MAX;
    return int'(value);
  endfunction

  function automatic void restart_section();
    level_sum    = 0;
    energy_sum   = 0;
    loaded_count = 0;
  endfunction

  function automatic void apply_reg_write(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_SECTION_LENGTH: begin
        // only the low byte is kept, and loading starts over
        mirror_length = value[LENGTH_W-1:0];
        restart_section();
      end
      REG_STD_FACTOR: begin
        mirror_factor = value[FACTOR_W-1:0];
      end
      default: begin
      end
    endcase
  endfunction

  // d^2 * 2^16 > k^2 * (N*Q - S^2), both sides wider than 64 bits
  function automatic bit above_threshold(input longint deviation, input longint spread);
    logic [127:0] lhs;
    logic [127:0] factor_sq;
    logic [127:0] rhs;
    lhs       = 128'(deviation * deviation) << THRESH_SHIFT;
    factor_sq = 128'(mirror_factor) * 128'(mirror_factor);
    rhs       = factor_sq * 128'(spread);
    return lhs > rhs;
  endfunction

  function automatic void absorb_sample(input logic signed [SAMPLE_BITS-1:0] x);
    int     len;
    int     count;
    int     last_beat;
    bit     found;
    longint centre;
    longint deviation;
    longint spread;
    beat_t  beat;
    len   = active_length(mirror_length);
    count = len + 2;
    section_samples[loaded_count] = x;
    level_sum  += longint'(x);
    energy_sum += longint'(x) * longint'(x);
    loaded_count++;
    if (loaded_count < count) return;

    spread    = longint'(count) * energy_sum - level_sum * level_sum;
    found     = 1'b0;
    last_beat = 0;
    // scan inner samples, a beat is held back until the next one shows
    // whether it is the last of the section
    for (int j = 1; j <= len; j++) begin
      centre = section_samples[j];
      if (section_samples[j-1] < centre && section_samples[j+1] < centre) begin
        deviation = longint'(count) * centre - level_sum;
        if (deviation > 0 && above_threshold(deviation, spread)) begin
          if (found) begin
            beat.offset = OFFSET_W'(last_beat);
            beat.valid  = 1'b1;
            beat.done   = 1'b0;
            expected_beats = {expected_beats, beat};
          end
          last_beat = j - 1;
          found     = 1'b1;
        end
      end
    end
    // closing beat: the last detected one, or an empty marker
    beat.offset = found ? OFFSET_W'(last_beat) : '0;
    beat.valid  = found;
    beat.done   = 1'b1;
    expected_beats = {expected_beats, beat};
    restart_section();
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  // one process watches all three channels at each edge
  always @(posedge clk) begin
    if (rst) begin
      mirror_length = LENGTH_RESET;
      mirror_factor = FACTOR_RESET;
      restart_section();
    end else begin
      if (cfg_valid && cfg_ready) apply_reg_write(cfg_index, cfg_data);
      if (s_tvalid && s_tready) absorb_sample(s_tdata[SAMPLE_BITS-1:0]);
      if (m_tvalid && m_tready) begin
        if (expected_beats.size() == 0) begin
          report_mismatch($sformatf("unexpected beat offset %0d valid %0b done %0b",
                                    m_tdata[OFFSET_W-1:0], m_tuser, m_tlast));
        end else begin
          head_beat = expected_beats.pop_front();
          if (m_tdata[OFFSET_W-1:0] !== head_beat.offset)
            report_mismatch($sformatf("beat_offset got %0d want %0d",
                                      m_tdata[OFFSET_W-1:0], head_beat.offset));
          if (m_tuser !== head_beat.valid)
            report_mismatch($sformatf("beat_valid got %0b want %0b",
                                      m_tuser, head_beat.valid));
          if (m_tlast !== head_beat.done)
            report_mismatch($sformatf("section_done got %0b want %0b",
                                      m_tlast, head_beat.done));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side: random stall bursts, or one long hold-off when requested
  // ---------------------------------------------------------------------------
  initial begin : beat_sink
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        m_tready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
        m_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // valid stays high on return so the next sample can follow back to back
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] x);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= x;
    do @(posedge clk); while (!s_tready);
    sent_items++;
  endtask

  // keep valid high when another write follows right away
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value,
                           input bit more = 1'b0);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (!more) cfg_valid <= 1'b0;
    if (idx == REG_SECTION_LENGTH) programmed_length = value[LENGTH_W-1:0];
  endtask

  // stop offering samples, collect every pending beat, let the block go idle
  task automatic settle_block();
    int waited;
    s_tvalid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (expected_beats.size() != 0 && waited < DRAIN_LIMIT);
    if (expected_beats.size() != 0) begin
      report_mismatch($sformatf("%0d expected beats never arrived",
                                expected_beats.size()));
      expected_beats.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_section(input logic [CFG_DATA_W-1:0] length_value,
                                 input logic [CFG_DATA_W-1:0] factor_value);
    settle_block();
    write_reg(REG_SECTION_LENGTH, length_value, 1'b1);
    write_reg(REG_STD_FACTOR, factor_value);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] shaped_sample(
      input shape_e shape, input int pos, input int len,
      input logic signed [SAMPLE_BITS-1:0] level);
    logic [31:0] noise;
    int          v;
    noise = $urandom();
    case (shape)
      SHAPE_FULL_RANGE: v = int'(noise[15:0]);
      SHAPE_SPIKES: begin
        // small noise around zero with a tall spike now and then
        if (noise[31:29] == 3'd0) v = $urandom_range(1000, 32767);
        else v = int'($signed(noise[6:0]));
      end
      SHAPE_ALTERNATE: begin
        // every odd position is a peak, the most beats a section can give
        if (pos % 2 == 1) v = $urandom_range(8000, 32767);
        else v = -int'($urandom_range(8000, 32768));
      end
      SHAPE_FLAT: v = int'(level);
      default: v = (pos == 1 || pos == len) ? 32767 : 0;
    endcase
    return v[SAMPLE_BITS-1:0];
  endfunction

  // one full section: boundary sample, inner samples, boundary sample
  task automatic send_section(input shape_e shape);
    int                            len;
    logic signed [SAMPLE_BITS-1:0] level;
    len   = active_length(programmed_length);
    level = shaped_sample(SHAPE_FULL_RANGE, 0, 0, '0);
    for (int pos = 0; pos < len + 2; pos++) begin
      // boundaries are zero one time in four, as outside the song
      if ((pos == 0 || pos == len + 1) && $urandom_range(0, 3) == 0)
        send_sample('0);
      else
        send_sample(shaped_sample(shape, pos, len, level));
    end
  endtask

  function automatic logic [CFG_DATA_W-1:0] random_length_value();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick < 16) return CFG_DATA_W'($urandom_range(1, 8));
    if (pick < 19) return CFG_DATA_W'($urandom_range(9, 40));
    return CFG_DATA_W'($urandom_range(41, 64));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_factor_value();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return CFG_DATA_W'(1023);
      2:       return CFG_DATA_W'($urandom_range(0, 300));
      default: return CFG_DATA_W'($urandom_range(0, 1023));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // hand-picked sections at the smallest lengths
  task automatic test_short_sections();
    // zero length acts as one window: sample extremes around one peak
    program_section('0, FACTOR_RESET);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    // equal neighbors are no strict maximum, so an empty closing beat
    send_sample(-16'sd1);
    send_sample(-16'sd1);
    send_sample(-16'sd1);
    // zero factor passes any sample above the mean
    program_section('0, '0);
    send_sample(16'sd5);
    send_sample(16'sd7);
    send_sample(-16'sd3);
    // widest factor with two candidate peaks
    program_section(CFG_DATA_W'(3), CFG_DATA_W'(1023));
    send_sample(16'sd0);
    send_sample(16'sd100);
    send_sample(16'sd0);
    send_sample(16'sd100);
    send_sample(16'sd0);
    // two equal tops side by side, then two separate peaks
    program_section(CFG_DATA_W'(3), CFG_DATA_W'(64));
    send_sample(-16'sd1);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(-16'sd1);
    send_sample(16'sd0);
    send_sample(16'sd0);
    send_sample(16'sd300);
    send_sample(-16'sd200);
    send_sample(SAMPLE_MAX);
    send_sample(16'sd0);
  endtask

  task automatic test_register_corners();
    // writes past the register list change nothing
    settle_block();
    write_reg(REG_SPARE_FIRST, CFG_DATA_W'(10'h3FF), 1'b1);
    write_reg(REG_SPARE_LAST, CFG_DATA_W'(10'h155), 1'b1);
    // only the low byte of the length is kept: 300 gives 44 windows
    write_reg(REG_SECTION_LENGTH, CFG_DATA_W'(300));
    send_section(SHAPE_SPIKES);

    // a length write in the middle of a load starts the section over
    program_section(CFG_DATA_W'(6), CFG_DATA_W'(128));
    send_sample(SAMPLE_MAX);
    send_sample(16'sd12);
    send_sample(SAMPLE_MIN);
    settle_block();
    write_reg(REG_SECTION_LENGTH, CFG_DATA_W'(4));
    send_section(SHAPE_ALTERNATE);

    // a factor write in the middle of a load applies to that section's scan
    settle_block();
    send_sample(16'sd0);
    send_sample(16'sd900);
    send_sample(16'sd10);
    settle_block();
    write_reg(REG_STD_FACTOR, '0);
    send_sample(16'sd20);
    send_sample(16'sd800);
    send_sample(16'sd0);
  endtask

  task automatic test_long_sections();
    // full length, beats at the first and the last offset
    program_section(CFG_DATA_W'(SECTION_MAX), CFG_DATA_W'(16));
    send_section(SHAPE_EDGE_PEAKS);
    // a length past the memory acts as full size; peaks at every odd spot
    program_section(CFG_DATA_W'(255), '0);
    send_section(SHAPE_ALTERNATE);
  endtask

  // long result stall while samples keep coming, the input must back up
  task automatic test_backpressure();
    program_section(CFG_DATA_W'(4), '0);
    hold_request = HOLD_CYCLES;
    repeat (4) send_section(SHAPE_ALTERNATE);
  endtask

  task automatic test_random_sections();
    int first_item;
    first_item = sent_items;
    while (sent_items - first_item < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0)
        program_section(random_length_value(), random_factor_value());
      send_section(shape_e'($urandom_range(0, 4)));
    end
  endtask

  // closing stretch with no gaps on either side
  task automatic test_steady_flow();
    int first_item;
    idle_on = 1'b0;
    program_section(CFG_DATA_W'($urandom_range(2, 6)), random_factor_value());
    first_item = sent_items;
    while (sent_items - first_item < STEADY_ITEMS)
      send_section(shape_e'($urandom_range(0, 4)));
  endtask

  initial begin : regression
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_short_sections();
    test_register_corners();
    test_long_sections();
    test_backpressure();
    test_random_sections();
    test_steady_flow();
    settle_block();
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : run_limit
    #RUN_LIMIT_NS;
    $display("Regression FAIL");
    $finish;
  end

endmodule
